// ===== hw/rtl/utf16le_to_utf8_transcoder_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-16LE to UTF-8 transcoder assertion macros
// Clocked on clk_i; the gated form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define U16U8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define U16U8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define U16U8_ASSERT(lbl, prop, msg)
`define U16U8_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  localparam int unsigned SPACE_MAX = 4096;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned CAP_RST   = 512;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QAW       = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
  } enc_t;

  // one queued word group: encoded bytes plus optional terminator
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            term;
  } job_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.nbytes   = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.nbytes   = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf16le_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// UTF-16LE code units in, UTF-8 bytes out, with space limit and terminator.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o  code_unit_i, new_string_i, last_unit_i
// out      out  out_valid_o/out_ready_i out_byte_o, is_terminator_o, last_byte_o
// cfg      in   cfg_we_i               cfg_wdata_i (out_capacity)
//
// One code unit is taken per cycle while the 2-entry queue has room.
// An item holds up to four encoded bytes plus an optional terminator. The
// single output register in the back end sets the pace at one byte per cycle
// while out_ready_i is high. Items pass the queue, cur_q and byte_q in order.
// Reset is immediate; no clearing pass. Input and output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16le_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int unsigned SpaceMax = SPACE_MAX
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      code_unit_i,
  input  logic             new_string_i,
  input  logic             last_unit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             is_terminator_o,
  output logic             last_byte_o
);

  logic push, pop, q_empty, q_full;
  job_t push_job, pop_job;

  u16u8_front #(
    .SpaceMax (SpaceMax)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .new_string_i (new_string_i),
    .last_unit_i  (last_unit_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  u16u8_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u16u8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (pop_job),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_terminator_o (is_terminator_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, tracks output space and encodes.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
#(
  parameter int unsigned SpaceMax = SPACE_MAX
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [15:0]      code_unit_i,
  input  logic             new_string_i,
  input  logic             last_unit_i,
  input  logic             q_full_i,
  output logic             push_o,
  output job_t             job_o
);

  localparam int unsigned SW = $clog2(SpaceMax + 1);
  localparam int unsigned CW = (SW > CAP_W) ? SW : CAP_W;
  localparam logic [SW-1:0] SPACE_RST =
    (CAP_RST > SpaceMax) ? SW'(SpaceMax) : SW'(CAP_RST);

  logic [CAP_W-1:0] cap_q;
  logic [SW-1:0]    space_q, space_d, space_cur, space_sub, load_space;
  logic             pend_q, pend_d, pend_cur;
  logic [9:0]       lead_q, lead_d, lead_cur;
  logic             accept, is_sur, have_cp, emit;
  logic [20:0]      cp;
  enc_t             enc;
  logic [2:0]       n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign load_space = (CW'(cap_q) > CW'(SpaceMax)) ? SW'(SpaceMax) : SW'(cap_q);

  always_comb begin
    space_cur = new_string_i ? load_space : space_q;
    pend_cur  = !new_string_i && pend_q;
    lead_cur  = new_string_i ? 10'd0 : lead_q;
    is_sur    = (code_unit_i[15:11] == 5'b11011);
    have_cp   = pend_cur || !is_sur;
    cp        = pend_cur ? (21'h10000 + 21'({lead_cur, code_unit_i[9:0]}))
                         : 21'(code_unit_i);
    enc       = utf8_encode(cp);
    emit      = have_cp && (space_cur > SW'(6));
    n         = emit ? enc.nbytes : 3'd0;
    space_sub = space_cur - SW'(n);
    space_d   = (last_unit_i && (space_sub != '0)) ? space_sub - SW'(1) : space_sub;
    pend_d    = !last_unit_i && !pend_cur && is_sur;
    lead_d    = pend_d ? code_unit_i[9:0] : 10'd0;
  end

  assign push_o       = accept && ((n != 3'd0) || last_unit_i);
  assign job_o.bytes  = enc.bytes;
  assign job_o.nbytes = n;
  assign job_o.term   = last_unit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_W'(CAP_RST);
      space_q <= SPACE_RST;
      pend_q  <= 1'b0;
      lead_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        space_q <= space_d;
        pend_q  <= pend_d;
        lead_q  <= lead_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_fifo.sv =====
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of encoded groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf16le_to_utf8_transcoder_defines.svh"

module u16u8_fifo
  import u16u8_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QAW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  `U16U8_ASSERT(a_count_bound, count_q <= (QAW+1)'(QDEPTH), "queue count overflow")
  `U16U8_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `U16U8_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued groups into output words, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf16le_to_utf8_transcoder_defines.svh"

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_terminator_o,
  output logic       last_byte_o
);

  job_t       cur_q;
  logic       cur_valid_q, cur_valid_d;
  logic [2:0] idx_q, idx_d, total;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       term_q, last_q;
  logic       in_data, last_idx, out_load, done;

  assign total    = cur_q.nbytes + {2'b00, cur_q.term};
  assign last_idx = (idx_q == total - 3'd1);
  assign in_data  = (idx_q < cur_q.nbytes);
  assign out_load = cur_valid_q && (!out_valid_q || out_ready_i);
  assign done     = out_load && last_idx;
  assign q_pop_o  = (!cur_valid_q || done) && !q_empty_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 3'd0;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else if (out_load) begin
      idx_d = idx_q + 3'd1;
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
    if (out_load) begin
      byte_q <= in_data ? cur_q.bytes[idx_q[1:0]] : 8'h00;
      term_q <= !in_data;
      last_q <= last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign is_terminator_o = term_q;
  assign last_byte_o     = last_q;

  `U16U8_ASSERT(a_idx_in_group, cur_valid_q |-> (idx_q < total), "word index past group end")

endmodule

`default_nettype wire
